### hw/rtl/sorted_deadline_timer_queue_macros.svh
// Assertion macros for the timer queue
`ifndef SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH
// Implication checked on every clock edge outside reset
`define SDTQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset
`define SDTQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

### hw/rtl/sdtq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtq_pkg
// Shared types and codes of the sorted deadline timer queue.
// ----------------------------------------------------------------------------
package sdtq_pkg;
  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_RESET   = 3'd1;
  localparam logic [2:0] OP_CANCEL  = 3'd2;
  localparam logic [2:0] OP_RUN     = 3'd3;
  localparam logic [2:0] OP_TIMEOUT = 3'd4;

  localparam logic [2:0] K_CREATED  = 3'd0;
  localparam logic [2:0] K_EXPIRED  = 3'd1;
  localparam logic [2:0] K_TIMEOUT  = 3'd2;
  localparam logic [2:0] K_NOTIMER  = 3'd3;
  localparam logic [2:0] K_DONE     = 3'd4;
  localparam logic [2:0] K_ERROR    = 3'd5;

  localparam logic [47:0] MAX48     = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] USEC_PER_SEC = 48'd1000000;
  // floor(2^42 / 15625): (t >> 16) * USEC_RECIP >> 32 undershoots t / 10^6 by under 2
  localparam logic [28:0] USEC_RECIP = 29'd281474976;

  typedef struct packed {
    logic [2:0]  op;
    logic [47:0] now_us;
    logic [31:0] period_us;
    logic        periodic;
    logic [31:0] client_tag;
    logic [3:0]  timer_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot_id;
    logic [31:0] tag_out;
    logic [28:0] timeout_sec;
    logic [19:0] timeout_usec;
    logic        last;
  } rsp_t;
endpackage

### hw/rtl/sdtq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtq_req_if (sdtq_rsp_if is defined in sdtq_rsp_if.sv)
// Valid/ready channel carrying requests; results use the sdtq_rsp_if channel.
// ----------------------------------------------------------------------------
interface sdtq_req_if;
  logic           valid;
  logic           ready;
  sdtq_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/sdtq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtq_rsp_if
// Valid/ready channel carrying result transactions.
// ----------------------------------------------------------------------------
interface sdtq_rsp_if;
  logic           valid;
  logic           ready;
  sdtq_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/sorted_deadline_timer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue
// Fixed-slot timer table with ordered expiry and timeout query.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req (valid/ready), each with op and the current
// time; results leave on rsp, one or more per request, last marking the end.
// The block works on one request at a time and drops ready while busy.
// A shared comparator walks the slots one per cycle to find the free slot or
// the earliest timer. Create, reset, cancel and a run that fires nothing scan
// the table once, act on the result and then raise rsp.valid; the next
// request is taken only after that result has been accepted.
// Run: each firing is followed by a fresh scan so that last is known before
// the held expiry leaves; the first result therefore follows two scans, and
// each further one follows a further scan once the one before is accepted.
// Timeout: the seconds are split off by a reciprocal multiply and two
// correction steps, and the remainder gives the microseconds.
// Results are held in an output register; if the receiver stalls, the
// sequencer waits with the result held. Synchronous reset clears all timers,
// the order counter and the channel state.
// ----------------------------------------------------------------------------
`include "sorted_deadline_timer_queue_macros.svh"
module sorted_deadline_timer_queue #(
  parameter int SLOTS     = 16,
  parameter int MAX_FIRES = 64
) (
  input logic clk,
  input logic rst,
  sdtq_req_if.sink   req,
  sdtq_rsp_if.source rsp
);
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FW = $clog2(MAX_FIRES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [47:0] deadline [SLOTS];
  logic [31:0] interval [SLOTS];
  logic [31:0] tag_store [SLOTS];
  logic [31:0] arm_order [SLOTS];
  logic [SLOTS-1:0] repeat_flag;
  logic [SLOTS-1:0] armed;
  logic [31:0] order_counter;

  logic [2:0]  state;
  sdtq_pkg::req_t cur;
  logic [SW-1:0] idx;
  logic          found;
  logic [SW-1:0] best;
  logic [47:0]   best_dl;
  logic [31:0]   best_ord;
  logic [FW-1:0] fires;
  logic          more;     // more results follow the one held
  logic          pend;     // an expiry waits for the next scan to settle last
  logic [SW-1:0] pend_slot;
  logic [31:0]   pend_tag;
  logic [2:0]    div_cnt;
  logic [47:0]   diff;
  logic [60:0]   prod;
  logic [47:0]   qm;
  logic [28:0]   quo;
  logic [47:0]   rem;
  logic          rsp_valid;
  sdtq_pkg::rsp_t rsp_q;

  logic [SW-1:0] id_idx;
  logic          id_ok;
  logic [47:0]   cand_dl;
  logic          better;
  logic          due;
  logic [47:0]   create_dl;
  logic [47:0]   reset_dl;
  logic [47:0]   rearm_dl;
  logic [48:0]   sum_tmp;

  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_q;

  function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? sdtq_pkg::MAX48 : s[47:0];
  endfunction

  function automatic sdtq_pkg::rsp_t mk_rsp(input logic [2:0] kind, input logic [3:0] slot,
                                            input logic [31:0] tag, input logic fin);
    sdtq_pkg::rsp_t r;
    r = '0;
    r.kind    = kind;
    r.slot_id = slot;
    r.tag_out = tag;
    r.last    = fin;
    return r;
  endfunction

  assign id_idx   = SW'(cur.timer_id);
  assign id_ok    = ({28'd0, cur.timer_id} < 32'(SLOTS)) && armed[id_idx];
  assign cand_dl  = deadline[idx];
  assign better   = armed[idx] && (!found || cand_dl < best_dl ||
                    (cand_dl == best_dl && arm_order[idx] < best_ord));
  assign due      = found && (best_dl <= cur.now_us) && (32'(fires) < 32'(MAX_FIRES));
  assign create_dl = sat_add(cur.now_us, cur.period_us);
  assign reset_dl  = sat_add(cur.now_us, interval[id_idx]);
  assign rearm_dl  = sat_add(best_dl, interval[best]);
  assign sum_tmp   = {1'b0, best_dl} - {1'b0, cur.now_us};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      armed <= '0;
      order_counter <= '0;
      rsp_valid <= 1'b0;
      fires <= '0;
      more <= 1'b0;
      pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur   <= req.payload;
            idx   <= '0;
            found <= 1'b0;
            fires <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // create hunts the lowest free slot, everything else the earliest timer
          if (cur.op == sdtq_pkg::OP_CREATE) begin
            if (!armed[idx] && !found) begin
              found <= 1'b1;
              best  <= idx;
            end
          end else if (better) begin
            found    <= 1'b1;
            best     <= idx;
            best_dl  <= cand_dl;
            best_ord <= arm_order[idx];
          end
          if (32'(idx) == 32'(SLOTS - 1)) state <= S_ACT;
          else idx <= idx + SW'(1);
        end
        S_ACT: begin
          case (cur.op)
            sdtq_pkg::OP_CREATE: begin
              state <= S_OUT;
              more  <= 1'b0;
              if (found) begin
                interval[best]    <= cur.period_us;
                repeat_flag[best] <= cur.periodic;
                tag_store[best]   <= cur.client_tag;
                deadline[best]    <= create_dl;
                arm_order[best]   <= order_counter;
                armed[best]       <= 1'b1;
                order_counter     <= order_counter + 32'd1;
                rsp_q <= mk_rsp(sdtq_pkg::K_CREATED, 4'(best), 32'd0, 1'b1);
              end else begin
                rsp_q <= mk_rsp(sdtq_pkg::K_ERROR, 4'd0, 32'd0, 1'b1);
              end
            end
            sdtq_pkg::OP_RESET, sdtq_pkg::OP_CANCEL: begin
              state <= S_OUT;
              more  <= 1'b0;
              if (id_ok) begin
                if (cur.op == sdtq_pkg::OP_RESET) begin
                  deadline[id_idx]  <= reset_dl;
                  arm_order[id_idx] <= order_counter;
                  order_counter <= order_counter + 32'd1;
                end else begin
                  armed[id_idx] <= 1'b0;
                end
                rsp_q <= mk_rsp(sdtq_pkg::K_DONE, 4'd0, 32'd0, 1'b1);
              end else begin
                rsp_q <= mk_rsp(sdtq_pkg::K_ERROR, 4'd0, 32'd0, 1'b1);
              end
            end
            sdtq_pkg::OP_RUN: begin
              if (due) begin
                if (repeat_flag[best]) begin
                  deadline[best]  <= rearm_dl;
                  arm_order[best] <= order_counter;
                  order_counter   <= order_counter + 32'd1;
                end else begin
                  armed[best] <= 1'b0;
                end
                fires     <= fires + FW'(1);
                pend      <= 1'b1;
                pend_slot <= best;
                pend_tag  <= tag_store[best];
              end else begin
                pend <= 1'b0;
              end
              if (pend) begin
                // release the held expiry; it is final when nothing more is due
                rsp_q <= mk_rsp(sdtq_pkg::K_EXPIRED, 4'(pend_slot), pend_tag, !due);
                more  <= due;
                state <= S_OUT;
              end else if (due) begin
                // rescan before the first result leaves
                more  <= 1'b0;
                idx   <= '0;
                found <= 1'b0;
                state <= S_SCAN;
              end else begin
                more  <= 1'b0;
                rsp_q <= mk_rsp(sdtq_pkg::K_DONE, 4'd0, 32'd0, 1'b1);
                state <= S_OUT;
              end
            end
            sdtq_pkg::OP_TIMEOUT: begin
              more <= 1'b0;
              if (found) begin
                rsp_q   <= mk_rsp(sdtq_pkg::K_TIMEOUT, 4'd0, 32'd0, 1'b1);
                diff    <= sum_tmp[48] ? 48'd0 : sum_tmp[47:0];
                div_cnt <= '0;
                state   <= S_DIV;
              end else begin
                rsp_q <= mk_rsp(sdtq_pkg::K_NOTIMER, 4'd0, 32'd0, 1'b1);
                state <= S_OUT;
              end
            end
            default: begin
              more  <= 1'b0;
              rsp_q <= mk_rsp(sdtq_pkg::K_ERROR, 4'd0, 32'd0, 1'b1);
              state <= S_OUT;
            end
          endcase
        end
        S_DIV: begin
          // estimate seconds by reciprocal, then correct the estimate upward
          div_cnt <= div_cnt + 3'd1;
          case (div_cnt)
            3'd0: prod <= {29'd0, diff[47:16]} * {32'd0, sdtq_pkg::USEC_RECIP};
            3'd1: quo  <= prod[60:32];
            3'd2: qm   <= {19'd0, quo} * sdtq_pkg::USEC_PER_SEC;
            3'd3: rem  <= diff - qm;
            default: begin
              if (rem >= sdtq_pkg::USEC_PER_SEC) begin
                rem <= rem - sdtq_pkg::USEC_PER_SEC;
                quo <= quo + 29'd1;
              end
              if (div_cnt == 3'd5) state <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          if (rsp_valid && rsp.ready) begin
            rsp_valid <= 1'b0;
            idx <= '0;
            found <= 1'b0;
            state <= more ? S_SCAN : S_IDLE;
          end else if (!rsp_valid) begin
            if (rsp_q.kind == sdtq_pkg::K_TIMEOUT) begin
              rsp_q.timeout_sec  <= quo;
              rsp_q.timeout_usec <= rem[19:0];
            end
            rsp_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SDTQ_ASSERT_IMP(a_busy_not_ready, state != S_IDLE, !req.ready, "ready while busy")
  `SDTQ_ASSERT_IMP(a_fire_cap, 1'b1, 32'(fires) <= 32'(MAX_FIRES), "fire count past limit")
  `SDTQ_ASSERT_NXT(a_hold, rsp_valid && !rsp.ready, $stable(rsp_q), "result changed under stall")
endmodule

### test/tb_sorted_deadline_timer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_deadline_timer_queue
// Self-checking bench for the sorted deadline timer queue: a directed opener
// (empty table, bad ids, unknown ops, zero-period timer, full table, tied
// deadlines, saturated deadline) followed by random timer traffic on a mostly
// advancing clock. Results are predicted in-bench and checked field by field,
// with random gaps on both channels and one long stall of the result side.
// ----------------------------------------------------------------------------
module tb_sorted_deadline_timer_queue;

  localparam int NSLOT      = 16;
  localparam int FIRE_LIMIT = 64;
  localparam int LONG_HOLD  = 3000;
  localparam int N_RANDOM   = 480;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sdtq_req_if req ();
  sdtq_rsp_if rsp ();

  sorted_deadline_timer_queue #(.SLOTS(NSLOT), .MAX_FIRES(FIRE_LIMIT)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  always #10 clk = ~clk;

  // Mirror of the timer table
  logic [47:0] tm_deadline [NSLOT];
  logic [31:0] tm_period   [NSLOT];
  logic        tm_repeat   [NSLOT];
  logic [31:0] tm_tag      [NSLOT];
  logic        tm_armed    [NSLOT];
  logic [31:0] tm_seq      [NSLOT];
  logic [31:0] seq_count;

  sdtq_pkg::req_t pending_reqs [$];
  sdtq_pkg::rsp_t expected_rsps [$];

  int n_sent;
  int n_results;
  int n_fired;
  int n_errors;
  int gap_left;
  int hold_left;
  logic long_hold;

  function automatic logic [47:0] add_sat48(logic [47:0] a, logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? sdtq_pkg::MAX48 : s[47:0];
  endfunction

  function automatic int earliest_timer();
    int best;
    best = -1;
    for (int s = 0; s < NSLOT; s++) begin
      if (tm_armed[s] && (best < 0 || tm_deadline[s] < tm_deadline[best] ||
          (tm_deadline[s] == tm_deadline[best] && tm_seq[s] < tm_seq[best])))
        best = s;
    end
    return best;
  endfunction

  task automatic arm_timer(int s, logic [47:0] when);
    tm_deadline[s] = when;
    tm_armed[s]    = 1'b1;
    tm_seq[s]      = seq_count;
    seq_count      = seq_count + 32'd1;
  endtask

  function automatic sdtq_pkg::rsp_t mk_rsp(logic [2:0] k);
    sdtq_pkg::rsp_t r;
    r = '0;
    r.kind = k;
    r.last = 1'b1;
    return r;
  endfunction

  // Apply one request to the mirror and queue its results
  task automatic predict_timer_op(sdtq_pkg::req_t q);
    sdtq_pkg::rsp_t r;
    int s, e, n;
    logic [47:0] diff;
    case (q.op)
      sdtq_pkg::OP_CREATE: begin
        s = -1;
        for (int i = NSLOT - 1; i >= 0; i--) if (!tm_armed[i]) s = i;
        if (s < 0) begin
          expected_rsps.push_back(mk_rsp(sdtq_pkg::K_ERROR));
        end else begin
          tm_period[s] = q.period_us;
          tm_repeat[s] = q.periodic;
          tm_tag[s]    = q.client_tag;
          arm_timer(s, add_sat48(q.now_us, q.period_us));
          r = mk_rsp(sdtq_pkg::K_CREATED);
          r.slot_id = s[3:0];
          expected_rsps.push_back(r);
        end
      end
      sdtq_pkg::OP_RESET, sdtq_pkg::OP_CANCEL: begin
        s = int'(q.timer_id);
        if (s >= NSLOT || !tm_armed[s]) begin
          expected_rsps.push_back(mk_rsp(sdtq_pkg::K_ERROR));
        end else begin
          if (q.op == sdtq_pkg::OP_RESET) arm_timer(s, add_sat48(q.now_us, tm_period[s]));
          else tm_armed[s] = 1'b0;
          expected_rsps.push_back(mk_rsp(sdtq_pkg::K_DONE));
        end
      end
      sdtq_pkg::OP_RUN: begin
        n = 0;
        while (n < FIRE_LIMIT) begin
          e = earliest_timer();
          if (e < 0 || tm_deadline[e] > q.now_us) break;
          r = mk_rsp(sdtq_pkg::K_EXPIRED);
          r.slot_id = e[3:0];
          r.tag_out = tm_tag[e];
          r.last    = 1'b0;
          expected_rsps.push_back(r);
          n++;
          if (tm_repeat[e]) arm_timer(e, add_sat48(tm_deadline[e], tm_period[e]));
          else tm_armed[e] = 1'b0;
        end
        if (n == 0) expected_rsps.push_back(mk_rsp(sdtq_pkg::K_DONE));
        else expected_rsps[$].last = 1'b1;
      end
      sdtq_pkg::OP_TIMEOUT: begin
        e = earliest_timer();
        if (e < 0) begin
          expected_rsps.push_back(mk_rsp(sdtq_pkg::K_NOTIMER));
        end else begin
          diff = tm_deadline[e] > q.now_us ? tm_deadline[e] - q.now_us : 48'd0;
          r = mk_rsp(sdtq_pkg::K_TIMEOUT);
          r.timeout_sec  = 29'(diff / sdtq_pkg::USEC_PER_SEC);
          r.timeout_usec = 20'(diff % sdtq_pkg::USEC_PER_SEC);
          expected_rsps.push_back(r);
        end
      end
      default: expected_rsps.push_back(mk_rsp(sdtq_pkg::K_ERROR));
    endcase
  endtask

  task automatic add_req(logic [2:0] op, logic [47:0] now, logic [31:0] period,
                         logic per, logic [31:0] tag, logic [3:0] id);
    sdtq_pkg::req_t q;
    q.op = op;
    q.now_us = now;
    q.period_us = period;
    q.periodic = per;
    q.client_tag = tag;
    q.timer_id = id;
    pending_reqs.push_back(q);
  endtask

  function automatic int pick_gap(int phase);
    int r;
    r = $urandom_range(0, 99);
    if ((phase / 40) % 3 == 0) return 0;  // quiet stretch
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.payload <= '0;
      gap_left = 0;
    end else begin
      if (req.valid && req.ready) begin
        predict_timer_op(req.payload);
        n_sent++;
      end
      if (!req.valid || req.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req.valid <= 1'b1;
          req.payload <= pending_reqs.pop_front();
          gap_left = pick_gap(n_sent);
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Long result-side stall once the table has had time to fill
  initial begin
    long_hold = 1'b0;
    while (n_sent < 120) @(posedge clk);
    long_hold = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    long_hold = 1'b0;
  end

  // Result monitor
  always @(posedge clk) begin
    sdtq_pkg::rsp_t got, exp_r;
    if (rst) begin
      rsp.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = rsp.payload;
        n_results++;
        if (got.kind == sdtq_pkg::K_EXPIRED) n_fired++;
        if (expected_rsps.size() == 0) begin
          $error("result with nothing expected: kind %0d", got.kind);
          n_errors++;
        end else begin
          exp_r = expected_rsps.pop_front();
          if (got.kind != exp_r.kind) begin
            $error("kind: expected %0d, got %0d", exp_r.kind, got.kind); n_errors++;
          end
          if (got.slot_id != exp_r.slot_id) begin
            $error("slot_id: expected %0d, got %0d", exp_r.slot_id, got.slot_id);
            n_errors++;
          end
          if (got.tag_out != exp_r.tag_out) begin
            $error("tag_out: expected %h, got %h", exp_r.tag_out, got.tag_out);
            n_errors++;
          end
          if (got.timeout_sec != exp_r.timeout_sec) begin
            $error("timeout_sec: expected %0d, got %0d", exp_r.timeout_sec,
                   got.timeout_sec);
            n_errors++;
          end
          if (got.timeout_usec != exp_r.timeout_usec) begin
            $error("timeout_usec: expected %0d, got %0d", exp_r.timeout_usec,
                   got.timeout_usec);
            n_errors++;
          end
          if (got.last != exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, got.last); n_errors++;
          end
        end
      end
      if (long_hold) begin
        rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        hold_left = pick_gap(n_results + 17);
      end
    end
  end

  initial begin
    logic [47:0] cur;
    int r;
    logic [31:0] per_v;
    for (int s = 0; s < NSLOT; s++) begin
      tm_deadline[s] = '0; tm_period[s] = '0; tm_repeat[s] = 1'b0;
      tm_tag[s] = '0; tm_armed[s] = 1'b0; tm_seq[s] = '0;
    end
    seq_count = '0;
    n_sent = 0; n_results = 0; n_fired = 0; n_errors = 0;
    req.valid = 1'b0;
    req.payload = '0;
    rsp.ready = 1'b0;

    // Directed opener
    add_req(sdtq_pkg::OP_TIMEOUT, 48'd5, 0, 0, 0, 0);            // empty table
    add_req(sdtq_pkg::OP_RUN, sdtq_pkg::MAX48, 0, 0, 0, 0);      // nothing to fire
    add_req(sdtq_pkg::OP_CANCEL, 48'd5, 0, 0, 0, 4'd3);          // slot not armed
    add_req(sdtq_pkg::OP_RESET, 48'd5, 0, 0, 0, 4'd15);
    add_req(3'd5, 48'd5, 0, 0, 0, 0);                            // unknown ops
    add_req(3'd6, 48'd5, 0, 0, 0, 0);
    add_req(3'd7, sdtq_pkg::MAX48, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 4'hF);
    add_req(sdtq_pkg::OP_CREATE, 48'd1000, 32'd0, 1, 32'hA5A5_0001, 0);  // zero period
    add_req(sdtq_pkg::OP_RUN, 48'd1000, 0, 0, 0, 0);             // hits fire limit
    add_req(sdtq_pkg::OP_CANCEL, 48'd1000, 0, 0, 0, 4'd0);
    for (int k = 0; k < NSLOT - 1; k++)                          // tied deadlines
      add_req(sdtq_pkg::OP_CREATE, 48'd2000, 32'((k % 3) * 100), (k == 5), $urandom, 0);
    add_req(sdtq_pkg::OP_CREATE, sdtq_pkg::MAX48 - 48'd5, 32'hFFFF_FFFF, 0, 32'h0, 0);
    add_req(sdtq_pkg::OP_CREATE, 48'd2000, 32'd7, 0, 32'h1234, 0);  // table full
    add_req(sdtq_pkg::OP_TIMEOUT, 48'd2500, 0, 0, 0, 0);         // past deadline
    add_req(sdtq_pkg::OP_RUN, 48'd2150, 0, 0, 0, 0);
    add_req(sdtq_pkg::OP_RESET, 48'd0, 0, 0, 0, 4'd15);
    add_req(sdtq_pkg::OP_TIMEOUT, 48'd0, 0, 0, 0, 0);
    add_req(sdtq_pkg::OP_RUN, sdtq_pkg::MAX48, 0, 0, 0, 0);      // hits fire limit

    // Random traffic on a mostly advancing clock
    cur = 48'd10000;
    for (int i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) cur = {$urandom, $urandom} & sdtq_pkg::MAX48;
      else if (r < 6) cur = cur - $urandom_range(0, 500);
      else cur = cur + $urandom_range(0, 800);
      r = $urandom_range(0, 99);
      per_v = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 1500);
      if (r < 30)
        add_req(sdtq_pkg::OP_CREATE, cur, per_v, ($urandom_range(0, 3) == 0) && per_v > 50,
                $urandom, 4'($urandom));
      else if (r < 54)
        add_req(sdtq_pkg::OP_RUN, cur, $urandom, 1'($urandom), $urandom, 4'($urandom));
      else if (r < 67)
        add_req(sdtq_pkg::OP_RESET, cur, $urandom, 1'($urandom), $urandom, 4'($urandom));
      else if (r < 83)
        add_req(sdtq_pkg::OP_CANCEL, cur, $urandom, 1'($urandom), $urandom, 4'($urandom));
      else if (r < 97)
        add_req(sdtq_pkg::OP_TIMEOUT, cur, $urandom, 1'($urandom), $urandom, 4'($urandom));
      else add_req(3'($urandom_range(5, 7)), cur, $urandom, 1'($urandom), $urandom,
                   4'($urandom));
    end
    add_req(sdtq_pkg::OP_RUN, sdtq_pkg::MAX48, 0, 0, 0, 0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req.valid) @(posedge clk);
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Run covered %0d requests, %0d results, %0d expirations checked.",
             n_sent, n_results, n_fired);
    if (n_errors == 0 && expected_rsps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
